// ===== src/etrb_pkg.sv =====
package etrb_pkg;

    localparam int DEPTH   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 5;
    localparam int OCNT_W  = 6;
    localparam int KEY_W   = 16;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_FIND   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0]   entity;
        logic [ID_W-1:0]   signal;
        logic [ID_W-1:0]   source;
        logic [ID_W-1:0]   mstate;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   entity_num;
        logic [ID_W-1:0]   signal_num;
        logic [ID_W-1:0]   source_id;
        logic [ID_W-1:0]   machine_state;
        logic [TIME_W-1:0] time_stamp;
        logic [IDX_W-1:0]  read_index;
    } t_in_beat;

    typedef struct packed {
        logic              hit;
        logic [ID_W-1:0]   out_entity;
        logic [ID_W-1:0]   out_signal;
        logic [ID_W-1:0]   out_source;
        logic [ID_W-1:0]   out_machine_state;
        logic [TIME_W-1:0] out_time;
        logic [OCNT_W-1:0] entry_count;
    } t_out_beat;

    // lookup token walking down the cell chain
    typedef struct packed {
        logic             valid;
        logic             is_find;
        logic             hit;
        logic [CNT_W-1:0] left;   // valid cells from this one to the oldest
        logic [KEY_W-1:0] key;    // entity for find, position+1 for read
        t_entry           data;
    } t_query;

    // reported count is the fill count masked to the output width
    function automatic logic [OCNT_W-1:0] out_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCNT_W-1:0] wide;
        wide = (CNT_W + OCNT_W)'(cnt);
        return wide[OCNT_W-1:0];
    endfunction

endpackage

// ===== src/event_trace_ring_buffer.sv =====
// Record and clear: result registered in the cycle after the input beat; one per cycle
//   while the output side keeps up.
// Read and find: the lookup token is registered at the chain head, walks the cell chain one
//   cell a cycle into the output register, and the next beat is taken once the result is out.
// Reset (i_rst_n low, synchronous): fill count zero, chain empty, no result pending.
//   Entry contents are not cleared; only cells below the fill count are ever looked at.
module event_trace_ring_buffer
    import etrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state           r_state;
    logic             r_out_valid;
    t_out_beat        r_out;
    logic [CNT_W-1:0] r_fill;
    t_query           r_inj;

    logic             w_accept;
    logic             w_take;
    logic             w_shift;
    logic             w_inject;
    logic             w_load;
    t_entry           w_new;

    // cell 0 holds the newest entry, cell DEPTH-1 the oldest
    t_entry           w_entry [DEPTH+1];
    t_query           w_q     [DEPTH+1];

    // one op in flight; the output register must be free (or emptying) to start one
    assign o_in_stall = (r_state == ST_WALK) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_take     = r_out_valid && !i_out_stall;
    assign w_shift    = w_accept && (i_in.op == OP_RECORD);
    assign w_inject   = w_accept && (i_in.op inside {OP_READ, OP_FIND});

    // a result lands in the output register: record/clear at once, lookups at chain end
    assign w_load     = (w_accept && (i_in.op inside {OP_RECORD, OP_CLEAR})) ||
                        ((r_state == ST_WALK) && w_q[DEPTH].valid);

    always_comb begin
        w_new.entity = i_in.entity_num;
        w_new.signal = i_in.signal_num;
        w_new.source = i_in.source_id;
        w_new.mstate = i_in.machine_state;
        w_new.stamp  = i_in.time_stamp;
    end

    assign w_entry[0] = w_new;
    assign w_q[0]     = r_inj;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        etrb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry (w_entry[g]),
            .o_entry (w_entry[g+1]),
            .i_q     (w_q[g]),
            .o_q     (w_q[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_inj.valid <= 1'b0;
        end else begin
            // token is live for one cycle at the chain head
            r_inj.valid <= w_inject;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_in.op)
                            OP_RECORD: begin
                                // saturate at DEPTH: oldest entry drops off the chain end
                                if (r_fill != CNT_W'(DEPTH)) begin
                                    r_fill <= r_fill + CNT_W'(1);
                                    r_out  <= '{entry_count: out_count(r_fill + CNT_W'(1)),
                                                default: '0};
                                end else begin
                                    r_out  <= '{entry_count: out_count(r_fill), default: '0};
                                end
                            end
                            OP_CLEAR: begin
                                r_fill      <= '0;
                                r_out       <= '0;
                            end
                            OP_READ: begin
                                // oldest-first position p lands where p+1 valid cells remain
                                r_inj.is_find <= 1'b0;
                                r_inj.hit     <= 1'b0;
                                r_inj.left    <= r_fill;
                                r_inj.key     <= KEY_W'(i_in.read_index) + KEY_W'(1);
                                r_inj.data    <= '0;
                                r_state       <= ST_WALK;
                            end
                            default: begin
                                // find: first match walking newest to oldest wins
                                r_inj.is_find <= 1'b1;
                                r_inj.hit     <= 1'b0;
                                r_inj.left    <= r_fill;
                                r_inj.key     <= i_in.entity_num;
                                r_inj.data    <= '0;
                                r_state       <= ST_WALK;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    if (w_q[DEPTH].valid) begin
                        r_out.hit         <= w_q[DEPTH].hit;
                        r_out.entry_count <= out_count(r_fill);
                        if (w_q[DEPTH].hit) begin
                            r_out.out_entity        <= w_q[DEPTH].data.entity;
                            r_out.out_signal        <= w_q[DEPTH].data.signal;
                            r_out.out_source        <= w_q[DEPTH].data.source;
                            r_out.out_machine_state <= w_q[DEPTH].data.mstate;
                            r_out.out_time          <= w_q[DEPTH].data.stamp;
                        end else begin
                            r_out.out_entity        <= '0;
                            r_out.out_signal        <= '0;
                            r_out.out_source        <= '0;
                            r_out.out_machine_state <= '0;
                            r_out.out_time          <= '0;
                        end
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/etrb_cell.sv =====
module etrb_cell
    import etrb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry,
    input  t_query i_q,
    output t_query o_q
);

    t_entry r_entry;
    t_query r_q;
    t_query n_q;
    logic   w_live;
    logic   w_match;

    // entries move one cell older on each record
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    always_comb begin
        w_live  = i_q.left != '0;
        w_match = i_q.valid && !i_q.hit && w_live &&
                  (i_q.is_find ? (r_entry.entity == i_q.key)
                               : (KEY_W'(i_q.left) == i_q.key));
        n_q = i_q;
        if (w_live) begin
            n_q.left = i_q.left - CNT_W'(1);
        end
        if (w_match) begin
            n_q.hit  = 1'b1;
            n_q.data = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_entry = r_entry;
    assign o_q     = r_q;

endmodule

// ===== src/etrb_checker.sv =====
module etrb_checker
    import etrb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out
);

    logic w_in_beat;
    assign w_in_beat = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_in.op == OP_CLEAR |=> o_out_valid && o_out.entry_count == '0)
        else $error("clear did not report an empty buffer");

    a_record_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_in.op == OP_RECORD |=> o_out_valid && !o_out.hit)
        else $error("record result missing or marked as hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.hit |-> o_out.out_entity == '0 && o_out.out_signal == '0 &&
            o_out.out_source == '0 && o_out.out_machine_state == '0 && o_out.out_time == '0)
        else $error("miss result carries entry data");

endmodule

bind event_trace_ring_buffer etrb_checker u_etrb_checker (.*);

// ===== verif/event_trace_ring_buffer_test.sv =====
module event_trace_ring_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import etrb_pkg::*;

    // Entities that come up often, so that finds hit and several entries
    // share one entity.
    localparam logic [ID_W-1:0] HOT_ENTITIES [6] = '{
        16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h00FF, 16'h7F00
    };
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = DEPTH + 8;  // a lookup's walk down the chain plus margin
    localparam int TARGET_BEATS     = 600;

    // ------------------------------------------------------------------
    // Mirror of the trace buffer. Each accepted input beat is applied to
    // the mirror, which yields the reply the block must give; replies are
    // checked in order against the queue of pending ones.
    // ------------------------------------------------------------------
    class trace_scoreboard;
        t_entry    cells [DEPTH];
        int        head;
        int        fill;
        t_out_beat pending [$];
        int        errors;
        int        n_record, n_overwrite, n_read, n_read_hit;
        int        n_find, n_find_hit, n_clear;

        function new();
            foreach (cells[i]) cells[i] = '0;
            head = 0;
            fill = 0;
        endfunction

        function void note_beat(t_in_beat b);
            t_out_beat r;
            int        slot;
            r = '0;
            case (b.op)
                OP_RECORD: begin
                    n_record++;
                    if (fill == DEPTH) n_overwrite++;
                    cells[head] = '{b.entity_num, b.signal_num, b.source_id,
                                    b.machine_state, b.time_stamp};
                    head = (head == DEPTH - 1) ? 0 : head + 1;
                    if (fill < DEPTH) fill++;
                end
                OP_READ: begin
                    n_read++;
                    // position 0 is the oldest live entry
                    if (int'(b.read_index) < fill) begin
                        slot = (head + DEPTH - fill + int'(b.read_index)) % DEPTH;
                        r.hit = 1'b1;
                        {r.out_entity, r.out_signal, r.out_source,
                         r.out_machine_state, r.out_time} = cells[slot];
                        n_read_hit++;
                    end
                end
                OP_FIND: begin
                    n_find++;
                    // newest to oldest, first match wins
                    for (int i = 0; i < fill; i++) begin
                        slot = (head + DEPTH - 1 - i) % DEPTH;
                        if (cells[slot].entity == b.entity_num) begin
                            r.hit = 1'b1;
                            {r.out_entity, r.out_signal, r.out_source,
                             r.out_machine_state, r.out_time} = cells[slot];
                            n_find_hit++;
                            break;
                        end
                    end
                end
                default: begin
                    n_clear++;
                    foreach (cells[i]) cells[i] = '0;
                    head = 0;
                    fill = 0;
                end
            endcase
            r.entry_count = fill[OCNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_reply(t_out_beat got);
            t_out_beat want;
            if (pending.size() == 0) begin
                $error("reply beat with nothing pending: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.out_entity !== want.out_entity) begin
                $error("out_entity: expected %h, got %h", want.out_entity, got.out_entity);
                errors++;
            end
            if (got.out_signal !== want.out_signal) begin
                $error("out_signal: expected %h, got %h", want.out_signal, got.out_signal);
                errors++;
            end
            if (got.out_source !== want.out_source) begin
                $error("out_source: expected %h, got %h", want.out_source, got.out_source);
                errors++;
            end
            if (got.out_machine_state !== want.out_machine_state) begin
                $error("out_machine_state: expected %h, got %h",
                       want.out_machine_state, got.out_machine_state);
                errors++;
            end
            if (got.out_time !== want.out_time) begin
                $error("out_time: expected %h, got %h", want.out_time, got.out_time);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;

    // knobs set by the stimulus; recv_idle and long_hold_req also steer the reply side
    bit send_idle;
    bit recv_idle;
    bit long_hold_req;

    trace_scoreboard sb = new;

    event_trace_ring_buffer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Both handshakes are sampled at the edge, before this edge's driver
    // updates land, so the order of processes in the step does not matter.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) sb.note_beat(in_beat);
        if (rst_n && out_valid && !out_stall) sb.check_reply(out_beat);
    end

    function automatic t_in_beat make_beat(t_op op, logic [ID_W-1:0] ent,
                                           logic [ID_W-1:0] sig, logic [ID_W-1:0] src,
                                           logic [ID_W-1:0] ms, logic [TIME_W-1:0] ts,
                                           logic [IDX_W-1:0] idx);
        t_in_beat b;
        b.op            = op;
        b.entity_num    = ent;
        b.signal_num    = sig;
        b.source_id     = src;
        b.machine_state = ms;
        b.time_stamp    = ts;
        b.read_index    = idx;
        return b;
    endfunction

    // record_pct: share of records; the rest is mostly reads and finds,
    // with an occasional clear.
    function automatic t_in_beat random_beat(int record_pct);
        t_in_beat b;
        int       roll;
        b.signal_num    = ID_W'($urandom);
        b.source_id     = ID_W'($urandom);
        b.machine_state = ID_W'($urandom);
        b.time_stamp    = $urandom;
        b.read_index    = IDX_W'($urandom);
        if ($urandom_range(0, 9) < 7)
            b.entity_num = HOT_ENTITIES[$urandom_range(0, 5)];
        else
            b.entity_num = ID_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < record_pct)
            b.op = OP_RECORD;
        else if (roll < 98)
            b.op = $urandom_range(0, 1) ? OP_READ : OP_FIND;
        else
            b.op = OP_CLEAR;
        return b;
    endfunction

    // Offer one beat and return at the edge where it is taken.
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = send_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    // Stop offering and wait until every expected reply has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() > 0);
    endtask

    // Reply side: a random stall before each beat, or one long hold-off
    // when the stimulus asks for it.
    initial begin : reply_side
        int hold;
        out_stall = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold_req) begin
                hold = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end else begin
                hold = recv_idle ? $urandom_range(0, 17) : 0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial begin : stimulus
        t_in_beat directed [$];
        int       sent;
        int       session;
        int       sess_len;
        int       record_pct;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_beat   = '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty lookups, field extremes, repeated entity,
        // lookups at and past the fill count, clear and lookups after it.
        directed.push_back(make_beat(OP_READ,   '0, '0, '0, '0, '0, 5'd0));
        directed.push_back(make_beat(OP_READ,   '0, '0, '0, '0, '0, 5'd31));
        directed.push_back(make_beat(OP_FIND,   16'h0000, '0, '0, '0, '0, '0));
        directed.push_back(make_beat(OP_RECORD, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_beat(OP_RECORD, '1, '1, '1, '1, '1, '1));
        directed.push_back(make_beat(OP_RECORD, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                                     32'hAAAA_AAAA, 5'h0A));
        directed.push_back(make_beat(OP_RECORD, 16'h1234, 16'h5555, 16'h5555, 16'h5555,
                                     32'h5555_5555, 5'h15));
        directed.push_back(make_beat(OP_RECORD, 16'h1234, 16'h0001, 16'h0002, 16'h0003,
                                     32'h8000_0001, 5'h00));
        directed.push_back(make_beat(OP_READ,   '0, '0, '0, '0, '0, 5'd0));
        directed.push_back(make_beat(OP_READ,   '0, '0, '0, '0, '0, 5'd4));
        directed.push_back(make_beat(OP_READ,   '0, '0, '0, '0, '0, 5'd5));
        directed.push_back(make_beat(OP_READ,   '1, '1, '1, '1, '1, 5'd31));
        directed.push_back(make_beat(OP_FIND,   16'h1234, '0, '0, '0, '0, '0));
        directed.push_back(make_beat(OP_FIND,   16'hFFFF, '0, '0, '0, '0, '0));
        directed.push_back(make_beat(OP_FIND,   16'h0000, '1, '1, '1, '1, '1));
        directed.push_back(make_beat(OP_FIND,   16'hBEEF, '0, '0, '0, '0, '0));
        directed.push_back(make_beat(OP_CLEAR,  '1, '1, '1, '1, '1, '1));
        directed.push_back(make_beat(OP_READ,   '0, '0, '0, '0, '0, 5'd0));
        directed.push_back(make_beat(OP_FIND,   16'h0000, '0, '0, '0, '0, '0));
        directed.push_back(make_beat(OP_CLEAR,  '0, '0, '0, '0, '0, '0));
        directed.push_back(make_beat(OP_RECORD, 16'h00FF, 16'h0F0F, 16'hF0F0, 16'h3C3C,
                                     32'h0000_FFFF, 5'h1F));
        directed.push_back(make_beat(OP_READ,   '0, '0, '0, '0, '0, 5'd0));
        foreach (directed[i]) send_beat(directed[i]);

        // Random sessions: each starts from a cleared buffer on a coin toss, and a
        // long one can run far enough that the head wraps and the count saturates.
        sent    = 0;
        session = 0;
        while (sent < TARGET_BEATS) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if (session == 2) begin
                // reply side holds off while records keep coming, so the
                // block backs up and stalls its input
                long_hold_req = 1'b1;
                send_idle     = 1'b0;
                repeat (40) send_beat(random_beat(100));
                sent += 40;
            end
            if (session == 4) wait_drained();
            if ($urandom_range(0, 1)) begin
                send_beat(random_beat(0) ^ '0);
                send_beat(make_beat(OP_CLEAR, ID_W'($urandom), ID_W'($urandom),
                                    ID_W'($urandom), ID_W'($urandom),
                                    $urandom, IDX_W'($urandom)));
                sent += 2;
            end
            sess_len   = $urandom_range(10, 90);
            record_pct = $urandom_range(25, 70);
            repeat (sess_len) send_beat(random_beat(record_pct));
            sent += sess_len;
            session++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d records (%0d overwrote the oldest), %0d clears",
                 sb.n_record, sb.n_overwrite, sb.n_clear);
        $display("covered %0d reads (%0d hits), %0d finds (%0d hits)",
                 sb.n_read, sb.n_read_hit, sb.n_find, sb.n_find_hit);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
